// ----- rtl/core/srgb_box_mip_chain_assert.svh -----
// assertion macros for the mip chain block
`ifndef SRGB_BOX_MIP_CHAIN_ASSERT_SVH
`define SRGB_BOX_MIP_CHAIN_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define SBMC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define SBMC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/sbmc_pkg.sv -----
// shared constants, types and srgb tables of the mip chain block
`default_nettype none
package sbmc_pkg;

  localparam int MAX_DIM    = 256;
  localparam int MAX_LEVELS = 9;
  localparam int DIM_W      = $clog2(MAX_DIM);
  localparam int SIZE_W     = DIM_W + 1;
  localparam int LVL_W      = $clog2(MAX_LEVELS);
  localparam int ADDR_W     = $clog2(MAX_LEVELS * MAX_DIM);
  localparam int QUEUE_DEPTH = 2;
  localparam int QCNT_W     = $clog2(QUEUE_DEPTH + 1);

  localparam logic [1:0] CFG_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_SRGB   = 2'd2;

  typedef struct packed {
    logic [7:0] alpha;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pix_t;

  typedef struct packed {
    logic valid;
    pix_t pix;
  } head_t;

  typedef struct packed {
    logic [SIZE_W-1:0] width;
    logic [SIZE_W-1:0] height;
    logic              srgb;
    logic              restart;
  } ctl_t;

  typedef logic [15:0] tab_t [256];

  localparam longint unsigned SRGB_DEN     = 510;
  localparam longint unsigned SRGB_LIN_DIV = 2584 * SRGB_DEN;
  localparam longint unsigned SRGB_POW_DIV = 1055 * SRGB_DEN;

  function automatic longint unsigned pow5q(input longint unsigned r);
    longint unsigned a;
    a = r;
    for (int k = 0; k < 4; k++) a = (a * r) >> 30;
    return a;
  endfunction

  function automatic logic [15:0] dec510(input longint unsigned n);
    longint unsigned tq, u, lo, hi, mid, lin;
    if (100000 * n <= 4045 * SRGB_DEN)
      return 16'((13107000 * n + 1292 * SRGB_DEN) / SRGB_LIN_DIV);
    tq = ((1000 * n + 55 * SRGB_DEN) << 30) / SRGB_POW_DIV;
    u  = (tq * tq) >> 30;
    lo = 0;
    hi = longint'(1) << 30;
    for (int i = 0; i < 40; i++) begin
      if (lo < hi) begin
        mid = (lo + hi + 1) >> 1;
        if (pow5q(mid) <= u) lo = mid;
        else hi = mid - 1;
      end
    end
    lin = (u * lo) >> 30;
    return 16'((lin * 65535 + (longint'(1) << 29)) >> 30);
  endfunction

  function automatic tab_t build_dec();
    tab_t t;
    for (int i = 0; i < 256; i++) t[i] = dec510(longint'(2 * i));
    return t;
  endfunction

  function automatic tab_t build_thr();
    tab_t t;
    t[0] = 16'd0;
    for (int i = 1; i < 256; i++) t[i] = dec510(longint'(2 * i - 1));
    return t;
  endfunction

  localparam tab_t DEC_ROM = build_dec();
  localparam tab_t THR_ROM = build_thr();

endpackage
`default_nettype wire

// ----- rtl/core/sbmc_front.sv -----
// input request queue in front of the level sequencer
`default_nettype none
module sbmc_front import sbmc_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  in_valid,
  output logic       in_stall,
  input  wire pix_t  in_pix,
  output head_t      head,
  input  wire logic  pop
);

  pix_t              slot_r [QUEUE_DEPTH];
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic [QCNT_W-1:0] tail;
  logic              push;

  assign in_stall = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign push     = in_valid && !in_stall;
  assign head.valid = (cnt_r != '0);
  assign head.pix   = slot_r[0];
  assign tail       = cnt_r - QCNT_W'(1);

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !(pop && head.valid)) cnt_nxt = cnt_r + QCNT_W'(1);
    else if (!push && pop && head.valid) cnt_nxt = cnt_r - QCNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head.valid) begin
      for (int i = 0; i < QUEUE_DEPTH - 1; i++) slot_r[i] <= slot_r[i+1];
      if (push) slot_r[tail[QCNT_W-2:0]] <= in_pix;
    end else if (push) begin
      slot_r[cnt_r[QCNT_W-2:0]] <= in_pix;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/sbmc_back.sv -----
// level sequencer: line store, box filter and result register
`default_nettype none
module sbmc_back import sbmc_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire head_t head,
  output logic       pop,
  input  wire ctl_t  ctl,
  output logic       out_valid,
  input  wire logic  out_stall,
  output logic [3:0] mip_level,
  output logic [6:0] pos_x,
  output logic [6:0] pos_y,
  output logic [7:0] red_out,
  output logic [7:0] green_out,
  output logic [7:0] blue_out,
  output logic [7:0] alpha_out,
  output logic       last_in_run,
  output logic       chain_done
);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_LEVEL = 6'b000010,
    ST_RD0   = 6'b000100,
    ST_RD1   = 6'b001000,
    ST_SUM   = 6'b010000,
    ST_ENC   = 6'b100000
  } state_t;

  typedef struct packed {
    logic [3:0]  level;
    logic [6:0]  x;
    logic [6:0]  y;
    logic [31:0] q;
    logic        done;
  } res_t;

  state_t            state_r, state_nxt;
  logic [31:0]       line_mem [MAX_LEVELS * MAX_DIM];
  logic [31:0]       rd_q;
  logic [31:0]       pair_r [MAX_LEVELS];
  logic [DIM_W-1:0]  col_r [MAX_LEVELS];
  logic [DIM_W-1:0]  row_r [MAX_LEVELS];
  logic [LVL_W-1:0]  s_r;
  logic [SIZE_W-1:0] sw_r, sh_r;
  logic [31:0]       p_r, tl_r, tr_r, bl_r, q_r;
  logic [DIM_W-1:0]  cx_r, cy_r;
  logic [1:0]        ch_r;
  logic [2:0]        bit_r;
  logic [7:0]        cnt_r;
  logic [15:0]       m_r;
  res_t              pend_r;
  logic              pend_v_r;
  res_t              out_r;
  logic              out_v_r, out_last_r;

  logic [DIM_W-1:0]  cx, cy;
  logic              active, inb, wr_line, wr_pair, produce, out_free, go;
  logic [ADDR_W-1:0] rd_addr, base_addr;
  logic              mem_we;
  logic [7:0]        ba, bb, bc, bd, t, nc, byte_res;
  logic [9:0]        sum_lin;
  logic [17:0]       sum_dec;
  logic              srgb_ch, byte_done;
  logic [31:0]       q_fin;
  logic [SIZE_W-1:0] tw, th;

  assign cx = col_r[s_r];
  assign cy = row_r[s_r];
  assign active = (SIZE_W'(s_r) + SIZE_W'(1) < SIZE_W'(MAX_LEVELS))
               && (sw_r > SIZE_W'(1) || sh_r > SIZE_W'(1));
  assign inb     = (SIZE_W'(cx) < sw_r) && (SIZE_W'(cy) < sh_r);
  assign wr_line = active && inb && sh_r > SIZE_W'(1) && !cy[0];
  assign wr_pair = active && inb && !wr_line && sw_r > SIZE_W'(1) && !cx[0];
  assign produce = active && inb && !wr_line && !wr_pair;
  assign out_free = !out_v_r || !out_stall;
  assign go = !pend_v_r || out_free;
  assign base_addr = ADDR_W'(s_r) << DIM_W;
  assign rd_addr = (state_r == ST_RD0) ? (base_addr | ADDR_W'(cx_r - DIM_W'(1)))
                                       : (base_addr | ADDR_W'(cx));
  assign mem_we = (state_r == ST_LEVEL) && go && wr_line;
  assign pop = (state_r == ST_IDLE) && head.valid;

  assign tw = (sw_r > SIZE_W'(1)) ? (sw_r >> 1) : SIZE_W'(1);
  assign th = (sh_r > SIZE_W'(1)) ? (sh_r >> 1) : SIZE_W'(1);

  assign ba = tl_r[ch_r*8 +: 8];
  assign bb = tr_r[ch_r*8 +: 8];
  assign bc = bl_r[ch_r*8 +: 8];
  assign bd = p_r[ch_r*8 +: 8];
  assign sum_lin = 10'(ba) + 10'(bb) + 10'(bc) + 10'(bd) + 10'd2;
  assign sum_dec = 18'(DEC_ROM[ba]) + 18'(DEC_ROM[bb]) + 18'(DEC_ROM[bc])
                 + 18'(DEC_ROM[bd]) + 18'd2;
  assign srgb_ch = ctl.srgb && (ch_r != 2'd3);
  assign t  = cnt_r | (8'd1 << bit_r);
  assign nc = (THR_ROM[t] <= m_r) ? t : cnt_r;

  always_comb begin
    byte_res  = sum_lin[9:2];
    byte_done = 1'b0;
    if (state_r == ST_SUM && !srgb_ch) begin
      byte_done = 1'b1;
    end else if (state_r == ST_ENC && bit_r == 3'd0) begin
      byte_res  = nc;
      byte_done = 1'b1;
    end
    q_fin = q_r;
    q_fin[ch_r*8 +: 8] = byte_res;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (head.valid) state_nxt = ST_LEVEL;
      ST_LEVEL: if (go) state_nxt = produce ? ST_RD0 : ST_IDLE;
      ST_RD0:   state_nxt = ST_RD1;
      ST_RD1:   state_nxt = ST_SUM;
      ST_SUM: begin
        if (srgb_ch) state_nxt = ST_ENC;
        else if (ch_r == 2'd3) state_nxt = ST_LEVEL;
      end
      ST_ENC:   if (bit_r == 3'd0) state_nxt = ST_SUM;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) line_mem[rd_addr] <= p_r;
    rd_q <= line_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
      for (int i = 0; i < MAX_LEVELS; i++) begin
        col_r[i] <= '0;
        row_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (out_v_r && !out_stall) out_v_r <= 1'b0;
      if (ctl.restart) begin
        for (int i = 0; i < MAX_LEVELS; i++) begin
          col_r[i] <= '0;
          row_r[i] <= '0;
        end
      end else if (state_r == ST_LEVEL && go && active) begin
        if (SIZE_W'(cx) + SIZE_W'(1) >= sw_r) begin
          col_r[s_r] <= '0;
          row_r[s_r] <= (SIZE_W'(cy) + SIZE_W'(1) >= sh_r) ? '0 : cy + DIM_W'(1);
        end else begin
          col_r[s_r] <= cx + DIM_W'(1);
        end
      end
      if (state_r == ST_LEVEL && go && pend_v_r) begin
        out_v_r  <= 1'b1;
        pend_v_r <= 1'b0;
      end
      if (byte_done && ch_r == 2'd3) pend_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        if (head.valid) begin
          p_r  <= head.pix;
          s_r  <= '0;
          sw_r <= ctl.width;
          sh_r <= ctl.height;
        end
      end
      ST_LEVEL: begin
        if (go) begin
          if (wr_pair) pair_r[s_r] <= p_r;
          if (pend_v_r) begin
            out_r      <= pend_r;
            out_last_r <= !produce;
          end
          cx_r <= cx;
          cy_r <= cy;
        end
      end
      ST_RD0: tr_r <= rd_q;
      ST_RD1: begin
        ch_r <= 2'd0;
        if (sw_r > SIZE_W'(1)) bl_r <= pair_r[s_r];
        else bl_r <= p_r;
        if (sh_r > SIZE_W'(1)) begin
          tl_r <= (sw_r > SIZE_W'(1)) ? rd_q : tr_r;
        end else begin
          tr_r <= p_r;
          tl_r <= (sw_r > SIZE_W'(1)) ? pair_r[s_r] : p_r;
        end
      end
      ST_SUM: begin
        if (srgb_ch) begin
          m_r   <= sum_dec[17:2];
          cnt_r <= 8'd0;
          bit_r <= 3'd7;
        end
      end
      ST_ENC: begin
        cnt_r <= nc;
        bit_r <= bit_r - 3'd1;
      end
      default: ;
    endcase
    if (byte_done) begin
      q_r <= q_fin;
      ch_r <= ch_r + 2'd1;
      if (ch_r == 2'd3) begin
        pend_r.level <= 4'(s_r) + 4'd1;
        pend_r.x     <= cx_r[DIM_W-1 -: 7];
        pend_r.y     <= cy_r[DIM_W-1 -: 7];
        pend_r.q     <= q_fin;
        pend_r.done  <= (tw == SIZE_W'(1)) && (th == SIZE_W'(1));
        p_r  <= q_fin;
        sw_r <= tw;
        sh_r <= th;
        s_r  <= s_r + LVL_W'(1);
      end
    end
  end

  assign out_valid   = out_v_r;
  assign mip_level   = out_r.level;
  assign pos_x       = out_r.x;
  assign pos_y       = out_r.y;
  assign red_out     = out_r.q[7:0];
  assign green_out   = out_r.q[15:8];
  assign blue_out    = out_r.q[23:16];
  assign alpha_out   = out_r.q[31:24];
  assign last_in_run = out_last_r;
  assign chain_done  = out_r.done;

endmodule
`default_nettype wire

// ----- rtl/core/srgb_box_mip_chain.sv -----
// top level of the streaming rgba8 mip chain generator
// usage:
//   base pixels enter on the in_ channel in raster order, one request per
//   pixel; results leave on the out_ channel tagged with level and position.
//   each pixel may cause up to eight results, one per lower level, level 1
//   first; last_in_run marks the final result of a pixel, chain_done the
//   1x1 result that ends the image.
//   cfg_ writes set width (index 0), height (index 1) and srgb mode (index 2);
//   a size write restarts the stream. write only while the block is idle.
// steps:
//   a pixel that only gets stored passes the queue and the idle and level
//   states of the sequencer; each result adds the line store reads and the
//   channel steps in linear mode, and in srgb mode also the 8-step threshold
//   search per colour channel.
//   a two-entry queue takes requests while the sequencer works.
// reset: sizes 256x256, linear mode, counters cleared.
// a stalled output holds its result; the sequencer then waits for the slot.
`default_nettype none
module srgb_box_mip_chain import sbmc_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] red_in,
  input  wire logic [7:0] green_in,
  input  wire logic [7:0] blue_in,
  input  wire logic [7:0] alpha_in,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [3:0]      mip_level,
  output logic [6:0]      pos_x,
  output logic [6:0]      pos_y,
  output logic [7:0]      red_out,
  output logic [7:0]      green_out,
  output logic [7:0]      blue_out,
  output logic [7:0]      alpha_out,
  output logic            last_in_run,
  output logic            chain_done,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [1:0] cfg_index,
  input  wire logic [8:0] cfg_data
);

  `include "srgb_box_mip_chain_assert.svh"

  logic [8:0] width_r, height_r;
  logic       srgb_r;
  logic       cfg_we;
  ctl_t       ctl;
  head_t      head;
  logic       pop;
  pix_t       in_pix;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 9'd256;
      height_r <= 9'd256;
      srgb_r   <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WIDTH:  width_r  <= cfg_data;
        CFG_HEIGHT: height_r <= cfg_data;
        CFG_SRGB:   srgb_r   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    ctl.width  = (width_r == '0) ? SIZE_W'(1)
               : (width_r > 9'(MAX_DIM)) ? SIZE_W'(MAX_DIM) : SIZE_W'(width_r);
    ctl.height = (height_r == '0) ? SIZE_W'(1)
               : (height_r > 9'(MAX_DIM)) ? SIZE_W'(MAX_DIM) : SIZE_W'(height_r);
    ctl.srgb    = srgb_r;
    ctl.restart = cfg_we && (cfg_index == CFG_WIDTH || cfg_index == CFG_HEIGHT);
  end

  assign in_pix.red   = red_in;
  assign in_pix.green = green_in;
  assign in_pix.blue  = blue_in;
  assign in_pix.alpha = alpha_in;

  sbmc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_pix   (in_pix),
    .head     (head),
    .pop      (pop)
  );

  sbmc_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .head        (head),
    .pop         (pop),
    .ctl         (ctl),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .mip_level   (mip_level),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .red_out     (red_out),
    .green_out   (green_out),
    .blue_out    (blue_out),
    .alpha_out   (alpha_out),
    .last_in_run (last_in_run),
    .chain_done  (chain_done)
  );

  `SBMC_ASSERT_NOW(a_done_is_last, out_valid && chain_done, last_in_run, "chain end not last")
  `SBMC_ASSERT_NOW(a_level_range, out_valid, mip_level != 4'd0 && mip_level <= 4'd8, "bad level")
  `SBMC_ASSERT_NEXT(a_pop_head, pop, !in_stall, "queue not drained after pop")

endmodule
`default_nettype wire
